[design/ssif_pkg.sv]
// Package for the state-space IIR filter.
// Field widths, fixed-point constants, opcodes and the cell control struct.
// No dependencies.
package ssif_pkg;

    localparam int COEF_W    = 18;
    localparam int STATE_W   = 40;
    localparam int FRAC_W    = 14;
    localparam int SAMPLE_W  = 16;
    localparam int OUT_W     = 32;
    localparam int IDX_W     = 1;
    localparam int PDATA_W   = 32;
    localparam int ORDER_DEF = 2;

    // coef * state, exact
    localparam int PROD_W = COEF_W + STATE_W;

    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

endpackage

[design/ssif_rnd_sat.sv]
// Round half up from 14 fraction bits and saturate to RES_W bits.
// Depends on ssif_pkg.
module ssif_rnd_sat
    import ssif_pkg::*;
#(
    parameter int IN_W   = 60,
    parameter int RES_W  = 40
) (
    input  logic signed [IN_W-1:0]  i_acc,
    output logic signed [RES_W-1:0] o_val
);

    localparam int SUM_W = IN_W + 1;
    localparam int SH_W  = SUM_W - FRAC_W;

    logic signed [SUM_W-1:0] w_sum;
    logic signed [SH_W-1:0]  w_sh;
    logic                    w_ovf;

    assign w_sum = SUM_W'(i_acc) + SUM_W'(1 << (FRAC_W - 1));
    assign w_sh  = w_sum[SUM_W-1:FRAC_W];
    // fits when every bit above the result's sign bit matches it
    assign w_ovf = !((&w_sh[SH_W-1:RES_W-1]) || !(|w_sh[SH_W-1:RES_W-1]));

    always_comb begin
        if (!w_ovf) begin
            o_val = w_sh[RES_W-1:0];
        end else if (w_sh[SH_W-1]) begin
            o_val = {1'b1, {(RES_W-1){1'b0}}};
        end else begin
            o_val = {1'b0, {(RES_W-1){1'b1}}};
        end
    end

endmodule

[design/ssif_cell.sv]
// One state element of the filter: holds x_i, adds its numerator product to
// y and subtracts its denominator product from feedback. Depends on ssif_pkg.
module ssif_cell
    import ssif_pkg::*;
#(
    parameter int ACC_W = 60
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_ctrl                i_ctrl,
    input  logic signed [STATE_W-1:0] i_load_value,
    input  logic signed [STATE_W-1:0] i_up_state,
    input  logic signed [COEF_W-1:0]  i_num_coef,
    input  logic signed [COEF_W-1:0]  i_den_coef,
    input  logic signed [ACC_W-1:0]   i_acc_y,
    input  logic signed [ACC_W-1:0]   i_acc_fb,
    output logic signed [ACC_W-1:0]   o_acc_y,
    output logic signed [ACC_W-1:0]   o_acc_fb,
    output logic signed [STATE_W-1:0] o_state
);

    logic signed [STATE_W-1:0] r_state;
    logic signed [STATE_W-1:0] n_state;
    logic signed [PROD_W-1:0]  w_num_prod;
    logic signed [PROD_W-1:0]  w_den_prod;

    assign w_num_prod = i_num_coef * r_state;
    assign w_den_prod = i_den_coef * r_state;

    assign o_acc_y  = i_acc_y + ACC_W'(w_num_prod);
    assign o_acc_fb = i_acc_fb - ACC_W'(w_den_prod);
    assign o_state  = r_state;

    always_comb begin
        n_state = r_state;
        if (i_ctrl.load) begin
            n_state = i_load_value;
        end else if (i_ctrl.shift) begin
            n_state = i_up_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[design/state_space_iir_filter.sv]
// State-space IIR filter, top level: APB coefficient registers, the cell row
// and the output buffer. Depends on ssif_pkg, ssif_cell, ssif_rnd_sat.
//
// The filter takes one item per clock while o_stall is low. A sample transfer
// produces one output transfer via the buffer; a load transfer writes one
// state element and produces nothing. The rate is set by the feedback path:
// every cell multiplies its state by its coefficients, the sums ripple down
// the row of ORDER cells, and the rounded and saturated feedback lands in the
// top cell's register at the same edge. Output goes through a two-entry
// buffer, so input is stalled only once both entries hold results that the
// downstream side has not taken. Coefficients sit at byte address 4*i (den
// first, then num), read back sign-extended; write them only when idle.
module state_space_iir_filter
    import ssif_pkg::*;
#(
    parameter int ORDER = ORDER_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // sample / load channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [0:0]                 i_opcode,
    input  logic [IDX_W-1:0]           i_state_index,
    input  logic signed [STATE_W-1:0]  i_state_value,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [OUT_W-1:0]    o_sample_out,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [$clog2(2*ORDER)+1:0] paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready
);

    localparam int CFG_IDX_W = $clog2(2 * ORDER);
    localparam int ADDR_W    = CFG_IDX_W + 2;
    localparam int ACC_W     = PROD_W + $clog2(ORDER + 1);

    logic signed [COEF_W-1:0] r_den [ORDER];
    logic signed [COEF_W-1:0] r_num [ORDER];

    logic                 w_cfg_wr;
    logic [CFG_IDX_W-1:0] w_cfg_idx;

    logic w_in_xfer;
    logic w_sample;
    logic w_load;
    logic w_out_xfer;

    logic signed [ACC_W-1:0]   w_acc_y  [ORDER+1];
    logic signed [ACC_W-1:0]   w_acc_fb [ORDER+1];
    logic signed [STATE_W-1:0] w_state  [ORDER];
    logic signed [STATE_W-1:0] w_top_next;
    logic signed [OUT_W-1:0]   w_y;

    logic                    r_out_valid;
    logic                    r_skid_valid;
    logic signed [OUT_W-1:0] r_out_data;
    logic signed [OUT_W-1:0] r_skid_data;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ORDER; i++) begin
                r_den[i] <= '0;
                r_num[i] <= '0;
            end
        end else if (w_cfg_wr) begin
            for (int i = 0; i < ORDER; i++) begin
                if (w_cfg_idx == CFG_IDX_W'(i)) begin
                    r_den[i] <= pwdata[COEF_W-1:0];
                end
                if (w_cfg_idx == CFG_IDX_W'(ORDER + i)) begin
                    r_num[i] <= pwdata[COEF_W-1:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int i = 0; i < ORDER; i++) begin
            if (w_cfg_idx == CFG_IDX_W'(i)) begin
                prdata = PDATA_W'(r_den[i]);
            end
            if (w_cfg_idx == CFG_IDX_W'(ORDER + i)) begin
                prdata = PDATA_W'(r_num[i]);
            end
        end
    end

    // ---------------- input side ----------------
    assign o_stall   = r_skid_valid;
    assign w_in_xfer = i_valid && !o_stall;
    assign w_sample  = w_in_xfer && (i_opcode == OP_SAMPLE);
    assign w_load    = w_in_xfer && (i_opcode == OP_LOAD);

    // y starts at zero, feedback starts at u with 28 fraction bits
    assign w_acc_y[0]  = '0;
    assign w_acc_fb[0] = ACC_W'(i_sample_in) <<< (2 * FRAC_W);

    // ---------------- cell row ----------------
    for (genvar i = 0; i < ORDER; i++) begin : g_cell
        localparam bit LOADABLE = (i < (1 << IDX_W));
        t_cell_ctrl                w_ctrl;
        logic signed [STATE_W-1:0] w_up;

        assign w_ctrl.shift = w_sample;
        assign w_ctrl.load  = LOADABLE && w_load && (i_state_index == IDX_W'(i));

        if (i == ORDER - 1) begin : g_top
            assign w_up = w_top_next;
        end else begin : g_mid
            assign w_up = w_state[i+1];
        end

        ssif_cell #(
            .ACC_W (ACC_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_load_value (i_state_value),
            .i_up_state   (w_up),
            .i_num_coef   (r_num[i]),
            .i_den_coef   (r_den[i]),
            .i_acc_y      (w_acc_y[i]),
            .i_acc_fb     (w_acc_fb[i]),
            .o_acc_y      (w_acc_y[i+1]),
            .o_acc_fb     (w_acc_fb[i+1]),
            .o_state      (w_state[i])
        );
    end

    ssif_rnd_sat #(
        .IN_W  (ACC_W),
        .RES_W (STATE_W)
    ) u_fb_sat (
        .i_acc (w_acc_fb[ORDER]),
        .o_val (w_top_next)
    );

    ssif_rnd_sat #(
        .IN_W  (ACC_W),
        .RES_W (OUT_W)
    ) u_y_sat (
        .i_acc (w_acc_y[ORDER]),
        .o_val (w_y)
    );

    // ---------------- output buffer ----------------
    assign w_out_xfer   = r_out_valid && !i_stall;
    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_xfer) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_sample) begin
            if (r_out_valid && !w_out_xfer) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_xfer) begin
                r_out_data <= r_skid_data;
            end
        end else if (w_sample) begin
            if (r_out_valid && !w_out_xfer) begin
                r_skid_data <= w_y;
            end else begin
                r_out_data <= w_y;
            end
        end
    end

`ifndef SYNTHESIS
    // skid entry only ever holds a result behind the main one
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without output entry");

    a_sample_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sample && !r_out_valid) |=> (r_out_valid && !r_skid_valid))
        else $error("sample transfer did not reach the output register");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !r_out_valid) |=> !r_out_valid)
        else $error("load transfer produced a result");

    a_stalled_sample_skids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sample && r_out_valid && i_stall) |=> r_skid_valid)
        else $error("result lost while output stalled");

    if (ORDER > 1) begin : g_shift_chk
        a_state_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            w_sample |=> (w_state[0] == $past(w_state[1])))
            else $error("state did not shift on sample transfer");
    end
`endif

endmodule

[verif/state_space_iir_filter_tb.sv]
// Self-checking testbench for state_space_iir_filter: a clocked driver and monitor, a
// bit-exact filter predictor, and coefficient writes over the APB port between phases.
// Depends on ssif_pkg and the filter RTL only.
module state_space_iir_filter_tb;
    import ssif_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FILT_ORDER     = ORDER_DEF;
    localparam int ADDR_W         = $clog2(2*FILT_ORDER) + 2;
    localparam int REG_STRIDE     = 4;
    localparam int SETTLE_CYCLES  = 4;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_PHASES    = 6;
    localparam int PHASE_ITEMS    = 310;
    localparam int MAX_REPORTS    = 10;

    localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0]  COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0]  COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0]  COEF_HALF = COEF_W'(1 << (FRAC_W-1));

    typedef enum int unsigned {
        REG_DEN_COEF_0,
        REG_DEN_COEF_1,
        REG_NUM_COEF_0,
        REG_NUM_COEF_1
    } t_coef_reg;

    typedef struct packed {
        t_opcode                     opcode;
        logic [IDX_W-1:0]            index;
        logic signed [STATE_W-1:0]   value;
        logic signed [SAMPLE_W-1:0]  sample;
    } t_filt_item;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic [0:0]                  i_opcode = OP_LOAD;
    logic [IDX_W-1:0]            i_state_index = '0;
    logic signed [STATE_W-1:0]   i_state_value = '0;
    logic signed [SAMPLE_W-1:0]  i_sample_in = '0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic signed [OUT_W-1:0]     o_sample_out;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [ADDR_W-1:0]           paddr = '0;
    logic [PDATA_W-1:0]          pwdata = '0;
    logic [PDATA_W-1:0]          prdata;
    logic                        pready;

    // predictor copy of the filter
    logic signed [COEF_W-1:0]    den_coef_m [FILT_ORDER];
    logic signed [COEF_W-1:0]    num_coef_m [FILT_ORDER];
    logic signed [STATE_W-1:0]   filt_state [FILT_ORDER];

    t_filt_item                  item_q [$];
    logic signed [OUT_W-1:0]     expected_outputs [$];

    int  send_gap = 0;
    int  rx_gap = 0;
    int  long_hold_left = 0;
    bit  long_hold_done = 1'b0;
    bit  long_hold_armed = 1'b0;
    bit  quiet_mode = 1'b0;
    int  idle_cycles = 0;
    int  mismatch_count = 0;
    int  outputs_checked = 0;
    int  samples_sent = 0;
    int  loads_sent = 0;
    int  coef_writes = 0;
    int  sat_outputs = 0;

    state_space_iir_filter #(.ORDER(FILT_ORDER)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_state_index (i_state_index),
        .i_state_value (i_state_value),
        .i_sample_in   (i_sample_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample_out  (o_sample_out),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint saturate_to(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w-1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // round half up to 14 fraction bits
    function automatic longint round_frac(input longint v);
        return (v + (longint'(1) <<< (FRAC_W-1))) >>> FRAC_W;
    endfunction

    // output from the old state, then shift and feed back into the top element
    function automatic logic signed [OUT_W-1:0] next_filter_output(
        input logic signed [SAMPLE_W-1:0] u
    );
        longint y_acc;
        longint fb_acc;
        longint y_sat;
        int     k;
        y_acc  = 0;
        fb_acc = longint'(u) <<< (2*FRAC_W);
        for (k = 0; k < FILT_ORDER; k++) begin
            y_acc  += longint'(num_coef_m[k]) * longint'(filt_state[k]);
            fb_acc -= longint'(den_coef_m[k]) * longint'(filt_state[k]);
        end
        y_sat = saturate_to(round_frac(y_acc), OUT_W);
        if (y_sat != round_frac(y_acc)) sat_outputs++;
        for (k = 0; k + 1 < FILT_ORDER; k++) filt_state[k] = filt_state[k+1];
        filt_state[FILT_ORDER-1] = STATE_W'(saturate_to(round_frac(fb_acc), STATE_W));
        return OUT_W'(y_sat);
    endfunction

    function automatic t_filt_item make_item(input t_opcode op, input logic [IDX_W-1:0] idx,
                                             input logic signed [STATE_W-1:0] val,
                                             input logic signed [SAMPLE_W-1:0] smp);
        t_filt_item it;
        it.opcode = op;
        it.index  = idx;
        it.value  = val;
        it.sample = smp;
        return it;
    endfunction

    function automatic void push_load(input int idx, input logic signed [STATE_W-1:0] val);
        item_q.push_back(make_item(OP_LOAD, IDX_W'(idx), val, SAMPLE_W'($urandom)));
    endfunction

    function automatic void push_sample(input logic signed [SAMPLE_W-1:0] u);
        item_q.push_back(make_item(OP_SAMPLE, IDX_W'($urandom), STATE_W'({$urandom, $urandom}),
                                   u));
    endfunction

    function automatic void push_random_item();
        logic signed [STATE_W-1:0]  val;
        logic signed [SAMPLE_W-1:0] smp;
        case ($urandom_range(0, 3))
            0:       val = STATE_W'({$urandom, $urandom});
            1:       val = STATE_W'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            2:       val = ($urandom_range(0, 1) != 0) ? STATE_MAX : STATE_MIN;
            default: val = STATE_W'($signed($urandom_range(0, 1 << 29)) - (1 << 28));
        endcase
        if ($urandom_range(0, 15) == 0)
            smp = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
        else
            smp = SAMPLE_W'($urandom);
        if ($urandom_range(0, 4) == 0) push_load($urandom_range(0, FILT_ORDER-1), val);
        else push_sample(smp);
    endfunction

    // junk in the upper bits of pwdata: only the low COEF_W bits count
    task automatic write_coef(input t_coef_reg which, input logic signed [COEF_W-1:0] val);
        logic [PDATA_W-1:0] wdata;
        int                 idx;
        idx   = int'(which);
        wdata = $urandom;
        wdata[COEF_W-1:0] = val;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * REG_STRIDE);
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < FILT_ORDER) den_coef_m[idx] = val;
        else num_coef_m[idx - FILT_ORDER] = val;
        coef_writes++;
    endtask

    task automatic set_coefs(input logic signed [COEF_W-1:0] d0,
                             input logic signed [COEF_W-1:0] d1,
                             input logic signed [COEF_W-1:0] n0,
                             input logic signed [COEF_W-1:0] n1);
        write_coef(REG_DEN_COEF_0, d0);
        write_coef(REG_DEN_COEF_1, d1);
        write_coef(REG_NUM_COEF_0, n0);
        write_coef(REG_NUM_COEF_1, n1);
    endtask

    function automatic logic signed [COEF_W-1:0] pick_coef(input int mode);
        case (mode)
            0: return COEF_W'($signed($urandom_range(0, 20000)) - 10000);
            1: return COEF_W'($urandom);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return COEF_MAX;
                    1:       return COEF_MIN;
                    2:       return '0;
                    default: return COEF_W'($urandom);
                endcase
            end
        endcase
    endfunction

    // loads emit nothing, so let trailing loads settle once the last output is in
    task automatic wait_idle();
        while (item_q.size() != 0 || i_valid || expected_outputs.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : driver
        t_filt_item nxt;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                if (i_opcode == OP_SAMPLE) begin
                    expected_outputs.push_back(next_filter_output(i_sample_in));
                    samples_sent++;
                end else begin
                    if (i_state_index < FILT_ORDER) filt_state[i_state_index] = i_state_value;
                    loads_sent++;
                end
            end
            if (i_valid && o_stall) begin
                // stalled transfer holds its payload
            end else if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                i_valid  <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 15) == 0) begin
                send_gap <= $urandom_range(1, 10) - 1;
                i_valid  <= 1'b0;
            end else if (item_q.size() != 0) begin
                nxt = item_q.pop_front();
                i_valid       <= 1'b1;
                i_opcode      <= nxt.opcode;
                i_state_index <= nxt.index;
                i_state_value <= nxt.value;
                i_sample_in   <= nxt.sample;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        logic signed [OUT_W-1:0] want;
        if (!i_rst_n) begin
            i_stall        <= 1'b0;
            rx_gap         <= 0;
            long_hold_left <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_outputs.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected output %0d, none pending", o_sample_out);
                end else begin
                    want = expected_outputs.pop_front();
                    outputs_checked++;
                    if (o_sample_out !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("sample_out mismatch: expected %0d, got %0d",
                                     want, o_sample_out);
                    end
                end
            end
            // long hold-off fills the output buffer and backs up the input
            if (long_hold_armed && !long_hold_done) begin
                long_hold_done <= 1'b1;
                long_hold_left <= LONG_HOLD - 1;
                i_stall        <= 1'b1;
            end else if (long_hold_left != 0) begin
                long_hold_left <= long_hold_left - 1;
                i_stall        <= 1'b1;
            end else if (rx_gap != 0) begin
                rx_gap  <= rx_gap - 1;
                i_stall <= 1'b1;
            end else if (!quiet_mode && $urandom_range(0, 11) == 0) begin
                rx_gap  <= $urandom_range(1, 10) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int ph;
        int n;
        int mode;
        for (n = 0; n < FILT_ORDER; n++) begin
            den_coef_m[n] = '0;
            num_coef_m[n] = '0;
            filt_state[n] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset coefficients: output stays zero, feedback is just u
        push_sample(16'sh7fff);
        push_sample(16'sh8000);
        push_sample(16'sd0);
        wait_idle();

        // coefficient and state extremes: saturation of output and state both ways
        set_coefs(COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN);
        push_load(0, STATE_MAX);
        push_load(1, STATE_MIN);
        push_sample(16'sh7fff);
        push_sample(16'sh8000);
        push_load(0, STATE_MIN);
        push_load(1, STATE_MAX);
        push_sample(-16'sd1);
        push_load(0, '0);
        push_load(1, '0);
        push_sample(16'sd1);
        push_sample(16'sd0);
        wait_idle();

        // half-LSB ties round upwards
        set_coefs(COEF_HALF, '0, COEF_HALF, -COEF_HALF);
        push_load(0, 40'sd1);
        push_load(1, 40'sd0);
        push_sample(16'sd0);
        push_load(0, -40'sd1);
        push_sample(16'sd0);
        push_load(1, 40'sd3);
        push_sample(16'sd5);
        push_sample(-16'sd5);
        wait_idle();

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            mode = ph % 3;
            set_coefs(pick_coef(mode), pick_coef(mode), pick_coef(mode), pick_coef(mode));
            if (ph == RAND_PHASES - 1) quiet_mode = 1'b1;
            if (ph == 1) long_hold_armed = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                push_random_item();
                // sender drains everything mid-phase once
                if (ph == 2 && n == PHASE_ITEMS / 2) wait_idle();
            end
            wait_idle();
        end

        $display("checked %0d outputs (%0d saturated) from %0d samples and %0d loads",
                 outputs_checked, sat_outputs, samples_sent, loads_sent);
        $display("%0d coefficient writes over %0d coefficient sets", coef_writes,
                 coef_writes / (2*FILT_ORDER));
        if (mismatch_count == 0 && expected_outputs.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
